### src/pngsu_pkg.sv
// Package with shared constants, codes and helper functions of the PNG unfilter block.
package pngsu_pkg;

    localparam int unsigned MaxWidthDefault = 4096;
    localparam int unsigned MaxBytesPerPixel = 4;
    localparam int unsigned MaxHeight = 4096;

    localparam logic [2:0] ModeGray       = 3'd0;
    localparam logic [2:0] ModeTruecolor  = 3'd2;
    localparam logic [2:0] ModeIndexed    = 3'd3;
    localparam logic [2:0] ModeGrayAlpha  = 3'd4;
    localparam logic [2:0] ModeTrueAlpha  = 3'd6;

    localparam logic [2:0] FiltNone    = 3'd0;
    localparam logic [2:0] FiltSub     = 3'd1;
    localparam logic [2:0] FiltUp      = 3'd2;
    localparam logic [2:0] FiltAverage = 3'd3;
    localparam logic [2:0] FiltPaeth   = 3'd4;

    localparam logic [1:0] RegColorMode   = 2'd0;
    localparam logic [1:0] RegImageWidth  = 2'd1;
    localparam logic [1:0] RegImageHeight = 2'd2;

    localparam logic [7:0] OpaqueAlpha = 8'hff;

    function automatic logic [2:0] bytes_per_pixel(input logic [2:0] mode);
        logic [2:0] n;
        case (mode)
            ModeGray:      n = 3'd1;
            ModeTruecolor: n = 3'd3;
            ModeIndexed:   n = 3'd1;
            ModeGrayAlpha: n = 3'd2;
            default:       n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] predict(input logic [2:0] filt, input logic [7:0] a,
                                           input logic [7:0] b, input logic [7:0] c);
        logic signed [10:0] p;
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [10:0] pa;
        logic [10:0] pb;
        logic [10:0] pc;
        logic [8:0] s;
        logic [7:0] res;
        p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
        da = p - $signed({3'b000, a});
        db = p - $signed({3'b000, b});
        dc = p - $signed({3'b000, c});
        pa = da[10] ? 11'(-da) : 11'(da);
        pb = db[10] ? 11'(-db) : 11'(db);
        pc = dc[10] ? 11'(-dc) : 11'(dc);
        s  = {1'b0, a} + {1'b0, b};
        case (filt)
            FiltSub:     res = a;
            FiltUp:      res = b;
            FiltAverage: res = s[8:1];
            FiltPaeth: begin
                if (pa <= pb && pa <= pc) begin
                    res = a;
                end else if (pb <= pc) begin
                    res = b;
                end else begin
                    res = c;
                end
            end
            default:     res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

### src/png_scanline_unfilter_pixel_decode_top.sv
// Top level of the PNG scanline unfilter and RGBA pixel packer.
// Takes one decompressed byte per cycle unless the output stalls, and emits one RGBA
// pixel per completed pixel. Each byte passes a three-step pipeline: the request reads the
// line buffer at its byte column, the next step rebuilds the byte and reads the palette,
// and the last step packs the pixel into the output register. Throughput is one request per
// cycle unless stalled; a pixel passes both stages and the output register. The line buffer holds
// MAX_WIDTH * 4 bytes, the palette 256 entries; both must be written before they are read.
module png_scanline_unfilter_pixel_decode_top #(
    parameter int unsigned MAX_WIDTH = pngsu_pkg::MaxWidthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_start_of_pass,
    input  logic [7:0]  i_palette_index,
    input  logic [31:0] i_palette_color,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pixel_color,
    output logic        o_end_of_row,
    output logic        o_end_of_pass,
    output logic        o_error,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import pngsu_pkg::*;

    localparam int unsigned LineBytes = MAX_WIDTH * MaxBytesPerPixel;
    localparam int unsigned AW = $clog2(LineBytes);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1) > 13 ? $clog2(MAX_WIDTH + 1) : 13;
    localparam int unsigned LW = (WW + 3 > CW + 1) ? WW + 3 : CW + 1;

    logic [2:0]  r_color_mode;
    logic [12:0] r_image_width;
    logic [12:0] r_image_height;

    logic [7:0]  r_line_buf [LineBytes];
    logic [31:0] r_palette [256];
    logic [7:0]  r_lb_q;
    logic [31:0] r_pal_q;

    logic          r_expect;
    logic          r_skip;
    logic [2:0]    r_filt;
    logic [CW-1:0] r_col;
    logic [1:0]    r_ch;
    logic [11:0]   r_row;

    logic          r_v1;
    logic          r_s1_clear;
    logic          r_s1_data;
    logic          r_s1_err;
    logic          r_s1_emit;
    logic          r_s1_eor;
    logic          r_s1_eop;
    logic          r_s1_use_b;
    logic          r_s1_inbuf;
    logic [AW-1:0] r_s1_addr;
    logic [7:0]    r_s1_x;
    logic [2:0]    r_s1_filt;
    logic [1:0]    r_s1_ch;

    logic [7:0]  r_left [4];
    logic [7:0]  r_ul [4];
    logic [31:0] r_asm;

    logic        r_v2;
    logic        r_s2_idx;
    logic        r_s2_err;
    logic        r_s2_eor;
    logic        r_s2_eop;
    logic [31:0] r_s2_color;

    logic        r_ov;
    logic [31:0] r_o_color;
    logic        r_o_eor;
    logic        r_o_eop;
    logic        r_o_err;

    logic out_free, mv2, free2, mv1, acc, stream_acc;
    logic expect_e, skip_e, load1, bad_filter, is_data;
    logic [2:0] bpp;
    logic [WW-1:0] eff_w;
    logic [12:0] eff_h;
    logic [LW-1:0] rowlen;
    logic [LW-1:0] col_next;
    logic last_ch, eor, eop;
    logic [11:0] row_e;
    logic [7:0] a, b, c, r;
    logic [31:0] asm_next, pre_color;
    logic cfg_wr;

    assign out_free = !r_ov || i_ready;
    assign mv2 = r_v2 && out_free;
    assign free2 = !r_v2 || mv2;
    assign mv1 = r_v1 && free2;
    assign o_ready = !r_v1 || mv1;
    assign acc = i_valid && o_ready;
    assign stream_acc = acc && !i_func;

    assign expect_e = i_start_of_pass ? 1'b1 : r_expect;
    assign skip_e = i_start_of_pass ? 1'b0 : r_skip;
    assign row_e = i_start_of_pass ? 12'd0 : r_row;
    assign bad_filter = i_stream_byte > 8'd4;
    assign is_data = !skip_e && !expect_e;
    assign load1 = stream_acc && !skip_e;

    assign bpp = bytes_per_pixel(r_color_mode);

    always_comb begin
        eff_w = WW'(r_image_width);
        if (r_image_width == 13'd0) begin
            eff_w = WW'(1);
        end else if (WW'(r_image_width) > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end
        eff_h = r_image_height;
        if (r_image_height == 13'd0) begin
            eff_h = 13'd1;
        end else if (r_image_height > 13'(MaxHeight)) begin
            eff_h = 13'(MaxHeight);
        end
    end

    assign rowlen = LW'(eff_w) * LW'(bpp);
    assign col_next = LW'(r_col) + LW'(1);
    assign last_ch = (3'(r_ch) + 3'd1) >= bpp;
    assign eor = last_ch && (col_next >= rowlen);
    assign eop = eor && ((13'(row_e) + 13'd1) >= eff_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect <= 1'b1;
            r_skip <= 1'b0;
            r_filt <= FiltNone;
            r_col <= '0;
            r_ch <= 2'd0;
            r_row <= 12'd0;
        end else if (stream_acc) begin
            r_skip <= skip_e;
            r_expect <= expect_e;
            r_row <= row_e;
            if (i_start_of_pass) begin
                r_col <= '0;
                r_ch <= 2'd0;
            end
            if (!skip_e && expect_e) begin
                if (bad_filter) begin
                    r_skip <= 1'b1;
                end else begin
                    r_filt <= i_stream_byte[2:0];
                    r_col <= '0;
                    r_ch <= 2'd0;
                    r_expect <= 1'b0;
                end
            end else if (is_data) begin
                r_col <= CW'(col_next);
                r_ch <= last_ch ? 2'd0 : r_ch + 2'd1;
                if (eor) begin
                    r_col <= '0;
                    r_ch <= 2'd0;
                    r_expect <= 1'b1;
                    r_row <= eop ? 12'd0 : row_e + 12'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= load1 || (r_v1 && !mv1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_s1_clear <= expect_e && !bad_filter;
            r_s1_err   <= expect_e && bad_filter;
            r_s1_data  <= !expect_e;
            r_s1_emit  <= (expect_e && bad_filter) || (!expect_e && last_ch);
            r_s1_eor   <= !expect_e && eor;
            r_s1_eop   <= !expect_e && eop;
            r_s1_inbuf <= LW'(r_col) < LW'(LineBytes);
            r_s1_use_b <= (row_e != 12'd0) && (LW'(r_col) < LW'(LineBytes));
            r_s1_addr  <= r_col[AW-1:0];
            r_s1_x     <= i_stream_byte;
            r_s1_filt  <= r_filt;
            r_s1_ch    <= r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1 && is_data) begin
            r_lb_q <= r_line_buf[r_col[AW-1:0]];
        end
        if (mv1 && r_s1_data && r_s1_inbuf) begin
            r_line_buf[r_s1_addr] <= r;
        end
    end

    assign a = r_left[r_s1_ch];
    assign b = r_s1_use_b ? r_lb_q : 8'd0;
    assign c = r_ul[r_s1_ch];
    assign r = r_s1_x + predict(r_s1_filt, a, b, c);
    assign asm_next = {r_asm[23:0], r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '{default: 8'd0};
            r_ul <= '{default: 8'd0};
            r_asm <= 32'd0;
        end else if (mv1) begin
            if (r_s1_clear) begin
                r_left <= '{default: 8'd0};
                r_ul <= '{default: 8'd0};
                r_asm <= 32'd0;
            end else if (r_s1_data) begin
                r_left[r_s1_ch] <= r;
                r_ul[r_s1_ch] <= b;
                r_asm <= r_s1_emit ? 32'd0 : asm_next;
            end
        end
    end

    always_comb begin
        case (r_color_mode)
            ModeGray:      pre_color = {asm_next[7:0], asm_next[7:0], asm_next[7:0],
                                        OpaqueAlpha};
            ModeTruecolor: pre_color = {asm_next[23:0], OpaqueAlpha};
            ModeGrayAlpha: pre_color = {asm_next[15:8], asm_next[15:8], asm_next[15:8],
                                        asm_next[7:0]};
            default:       pre_color = asm_next;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_func) begin
            r_palette[i_palette_index] <= i_palette_color;
        end
        if (mv1) begin
            r_pal_q <= r_palette[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= (mv1 && r_s1_emit) || (r_v2 && !mv2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r_s2_err   <= r_s1_err;
            r_s2_idx   <= !r_s1_err && (r_color_mode == ModeIndexed);
            r_s2_eor   <= r_s1_eor;
            r_s2_eop   <= r_s1_eop;
            r_s2_color <= r_s1_err ? 32'd0 : pre_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= mv2 || (r_ov && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r_o_color <= r_s2_idx ? r_pal_q : r_s2_color;
            r_o_eor   <= r_s2_eor;
            r_o_eop   <= r_s2_eop;
            r_o_err   <= r_s2_err;
        end
    end

    assign o_valid = r_ov;
    assign o_pixel_color = r_o_color;
    assign o_end_of_row = r_o_eor;
    assign o_end_of_pass = r_o_eop;
    assign o_error = r_o_err;

    assign cfg_wr = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= ModeTrueAlpha;
            r_image_width <= 13'd1;
            r_image_height <= 13'd1;
        end else if (cfg_wr) begin
            case (i_paddr[3:2])
                RegColorMode:   r_color_mode <= i_pwdata[2:0];
                RegImageWidth:  r_image_width <= i_pwdata[12:0];
                RegImageHeight: r_image_height <= i_pwdata[12:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            RegColorMode:   o_prdata = {29'd0, r_color_mode};
            RegImageWidth:  o_prdata = {19'd0, r_image_width};
            RegImageHeight: o_prdata = {19'd0, r_image_height};
            default:        o_prdata = 32'd0;
        endcase
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load1 |-> (!r_v1 || mv1)) else $error("Stage one overwritten while occupied.");

    a_err_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stream_acc && !skip_e && expect_e && bad_filter) |=> r_skip)
        else $error("Bad filter type did not start skipping.");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_s2_err) |-> (!r_s2_eor && !r_s2_eop && r_s2_color == 32'd0))
        else $error("Error result carries pixel flags.");

endmodule
